FILE: hdl/lcmlt_pkg.sv
package lcmlt_pkg;

    localparam int XBITS_DEFAULT = 10;
    localparam int CFG_AW = 3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic {
        REG_DOMAIN_LOW  = 1'b0,
        REG_DOMAIN_HIGH = 1'b1
    } t_reg_idx;

    localparam logic signed [63:0] EMPTY_VALUE = -64'sd1000000000000000000;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [63:0] intercept;
    } t_line;

    localparam t_line EMPTY_LINE = '{slope: 32'sd0, intercept: EMPTY_VALUE};

    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
    } t_domain;

    typedef struct packed {
        t_line              node;
        t_line              carry;
        logic signed [31:0] xa;
        logic signed [31:0] xm;
    } t_eval_req;

    typedef struct packed {
        logic signed [63:0] v_nl;
        logic signed [63:0] v_nm;
        logic signed [63:0] v_cl;
        logic signed [63:0] v_cm;
    } t_eval_res;

endpackage

FILE: hdl/lcmlt_cfg_regs.sv
module lcmlt_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcmlt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output lcmlt_pkg::t_domain          o_domain
);

    logic signed [31:0]   r_low;
    logic signed [31:0]   r_high;
    lcmlt_pkg::t_reg_idx  w_idx;
    logic                 w_wr;

    assign w_idx  = lcmlt_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 32'sd0;
            r_high <= 32'sd1024;
        end else if (w_wr) begin
            unique case (w_idx)
                lcmlt_pkg::REG_DOMAIN_LOW:  r_low  <= pwdata;
                lcmlt_pkg::REG_DOMAIN_HIGH: r_high <= pwdata;
                default:                    r_low  <= r_low;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lcmlt_pkg::REG_DOMAIN_LOW:  prdata = r_low;
            lcmlt_pkg::REG_DOMAIN_HIGH: prdata = r_high;
            default:                    prdata = '0;
        endcase
    end

    assign o_domain.low  = r_low;
    assign o_domain.high = r_high;

endmodule

FILE: hdl/lcmlt_node_mem.sv
module lcmlt_node_mem #(
    parameter int XBITS = lcmlt_pkg::XBITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [XBITS:0]       i_rd_addr,
    output lcmlt_pkg::t_line     o_rd_data,
    input  logic                 i_wr_en,
    input  logic [XBITS:0]       i_wr_addr,
    input  lcmlt_pkg::t_line     i_wr_data,
    output logic                 o_busy
);

    localparam int AW    = XBITS + 1;
    localparam int DEPTH = 1 << AW;

    lcmlt_pkg::t_line mem [DEPTH];
    lcmlt_pkg::t_line r_rd_data;
    logic             r_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    lcmlt_pkg::t_line w_wd;

    // After reset every node is swept to the empty line, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == {AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_we = r_busy || i_wr_en;
    assign w_wa = r_busy ? r_clr_addr : i_wr_addr;
    assign w_wd = r_busy ? lcmlt_pkg::EMPTY_LINE : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: hdl/lcmlt_line_eval.sv
module lcmlt_line_eval (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  lcmlt_pkg::t_eval_req  i_req,
    output lcmlt_pkg::t_eval_res  o_res
);

    logic signed [63:0] r_p_nl;
    logic signed [63:0] r_p_nm;
    logic signed [63:0] r_p_cl;
    logic signed [63:0] r_p_cm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_nl <= i_req.node.slope * i_req.xa;
            r_p_nm <= i_req.node.slope * i_req.xm;
            r_p_cl <= i_req.carry.slope * i_req.xa;
            r_p_cm <= i_req.carry.slope * i_req.xm;
        end
    end

    // The lines are held steady until the sums are consumed in the cycle after the products are registered.
    assign o_res.v_nl = r_p_nl + i_req.node.intercept;
    assign o_res.v_nm = r_p_nm + i_req.node.intercept;
    assign o_res.v_cl = r_p_cl + i_req.carry.intercept;
    assign o_res.v_cm = r_p_cm + i_req.carry.intercept;

endmodule

FILE: hdl/li_chao_max_line_tree.sv
// Li Chao tree keeping the upper envelope of lines y = m*x + b over the integer
// domain [domain_low, domain_high). An insert request (func 0) gives no result;
// a query request (func 1) gives one result with the largest line value at
// query_x, or -1e18 if none. The nodes live in one memory of 2^(XBITS+1)
// entries; after reset a clearing pass over every entry runs before the
// first request is taken (configuration writes are taken at any time). Each
// tree level goes through the single node memory and the shared line
// evaluator in order: memory read, multiply, then add, compare and write back.
// A walk visits at most ceil(log2(span)) + 1 levels, never more than XBITS + 1.
// With a bad span an insert ends without walking the tree, and a query returns
// -1e18 with bad_span set, also without a walk.
module li_chao_max_line_tree #(
    parameter int XBITS = lcmlt_pkg::XBITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcmlt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic signed [31:0]           i_slope,
    input  logic signed [61:0]           i_intercept,
    input  logic signed [31:0]           i_query_x,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [63:0]           o_max_value,
    output logic                         o_bad_span
);

    localparam int AW = XBITS + 1;
    localparam logic signed [32:0] SPAN_MAX = 33'sd1 <<< XBITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_CMP,
        S_PUSH
    } t_state;

    lcmlt_pkg::t_domain   w_domain;
    lcmlt_pkg::t_line     w_node;
    lcmlt_pkg::t_eval_req w_req;
    lcmlt_pkg::t_eval_res w_res;
    logic                 w_mem_busy;
    logic                 w_rd_en;
    logic                 w_wr_en;
    logic                 w_in_acc;
    logic signed [32:0]   w_span_cfg;
    logic                 w_bad_cfg;
    logic                 w_left_better;
    logic                 w_mid_better;
    logic                 w_go_left;
    logic                 w_last;

    t_state               r_state, n_state;
    logic                 r_func, n_func;
    logic signed [31:0]   r_l, n_l;
    logic [AW-1:0]        r_span, n_span;
    logic [AW-1:0]        r_idx, n_idx;
    logic signed [31:0]   r_mid, n_mid;
    logic signed [31:0]   r_x, n_x;
    lcmlt_pkg::t_line     r_car, n_car;
    logic signed [63:0]   r_best, n_best;
    logic                 r_bad, n_bad;
    logic                 r_out_valid, n_out_valid;
    logic signed [63:0]   r_out_max, n_out_max;
    logic                 r_out_bad, n_out_bad;

    lcmlt_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_domain (w_domain)
    );

    lcmlt_node_mem #(
        .XBITS (XBITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_node),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_car),
        .o_busy    (w_mem_busy)
    );

    assign w_req.node  = w_node;
    assign w_req.carry = r_car;
    assign w_req.xa    = (r_func == lcmlt_pkg::FUNC_QUERY) ? r_x : r_l;
    assign w_req.xm    = r_mid;

    lcmlt_line_eval u_eval (
        .i_clk (i_clk),
        .i_en  (r_state == S_MUL),
        .i_req (w_req),
        .o_res (w_res)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !w_mem_busy;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_span_cfg  = {w_domain.high[31], w_domain.high} - {w_domain.low[31], w_domain.low};
    assign w_bad_cfg   = (w_span_cfg < 33'sd1) || (w_span_cfg > SPAN_MAX);

    assign w_left_better = w_res.v_cl > w_res.v_nl;
    assign w_mid_better  = w_res.v_cm > w_res.v_nm;
    assign w_go_left     = (r_func == lcmlt_pkg::FUNC_QUERY) ? (r_x < r_mid)
                                                             : (w_left_better != w_mid_better);
    assign w_last        = (r_span <= AW'(1)) || r_idx[AW-1];

    assign w_rd_en = (r_state == S_READ);
    assign w_wr_en = (r_state == S_CMP) && (r_func == lcmlt_pkg::FUNC_INSERT) && w_mid_better;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_l         = r_l;
        n_span      = r_span;
        n_idx       = r_idx;
        n_mid       = r_mid;
        n_x         = r_x;
        n_car       = r_car;
        n_best      = r_best;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_max   = r_out_max;
        n_out_bad   = r_out_bad;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func          = i_func;
                    n_l             = w_domain.low;
                    n_span          = w_span_cfg[AW-1:0];
                    n_idx           = AW'(1);
                    n_x             = i_query_x;
                    n_car.slope     = i_slope;
                    n_car.intercept = {{2{i_intercept[61]}}, i_intercept};
                    n_best          = lcmlt_pkg::EMPTY_VALUE;
                    n_bad           = w_bad_cfg;
                    if (!w_bad_cfg) begin
                        n_state = S_READ;
                    end else if (i_func == lcmlt_pkg::FUNC_QUERY) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_READ: begin
                n_mid   = r_l + 32'(r_span >> 1);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_func == lcmlt_pkg::FUNC_INSERT) begin
                    // The line that loses at mid travels on to the child.
                    if (w_mid_better) begin
                        n_car = w_node;
                    end
                end else if (w_res.v_nl > r_best) begin
                    n_best = w_res.v_nl;
                end
                if (w_last) begin
                    n_state = (r_func == lcmlt_pkg::FUNC_QUERY) ? S_PUSH : S_IDLE;
                end else begin
                    n_state = S_READ;
                    if (w_go_left) begin
                        n_span = r_span >> 1;
                        n_idx  = {r_idx[AW-2:0], 1'b0};
                    end else begin
                        n_l    = r_mid;
                        n_span = r_span - (r_span >> 1);
                        n_idx  = {r_idx[AW-2:0], 1'b1};
                    end
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_best;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_func      <= n_func;
            r_l         <= n_l;
            r_span      <= n_span;
            r_idx       <= n_idx;
            r_mid       <= n_mid;
            r_x         <= n_x;
            r_car       <= n_car;
            r_best      <= n_best;
            r_bad       <= n_bad;
            r_out_max   <= n_out_max;
            r_out_bad   <= n_out_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_value = r_out_max;
    assign o_bad_span  = r_out_bad;

`ifndef NO_ASSERTIONS
    a_walk_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_mem_busy)
        else $error("tree walk while the node memory is still clearing");

    a_walk_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ((r_idx != '0) && (r_span != '0)))
        else $error("node read with an empty span or a null heap index");

    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_PUSH))
        else $error("result posted outside the push step");

    a_insert_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) && (r_func == lcmlt_pkg::FUNC_INSERT)) |=> (r_state != S_PUSH))
        else $error("insert request heading toward a result");
`endif

endmodule
